[src/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// shared constants for the rotation matrix to quaternion pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  localparam int unsigned NumComp = 4;
  localparam int unsigned OutW    = 16;
  localparam int unsigned OutMax  = 32767;

  typedef logic [NumComp-1:0] negs_t;

endpackage

`default_nettype wire

[src/rmq_isqrt.sv]
// ----------------------------------------------------------------------------
// rmq_isqrt
// pipelined integer square root, one root bit per stage, several lanes
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_isqrt #(
  parameter int unsigned RadW  = 30,
  parameter int unsigned Lanes = 1,
  parameter int unsigned SideW = 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               vld_i,
  input  logic [Lanes-1:0][RadW-1:0]         rad_i,
  input  logic [SideW-1:0]                   side_i,
  output logic                               vld_o,
  output logic [Lanes-1:0][RadW/2-1:0]       root_o,
  output logic [SideW-1:0]                   side_o
);

  localparam int unsigned RootW = RadW / 2;
  localparam int unsigned RemW  = RootW + 2;

  logic [RootW-1:0]                 vld_q;
  logic [Lanes-1:0][RadW-1:0]       rad_q  [RootW];
  logic [Lanes-1:0][RemW-1:0]       rem_q  [RootW];
  logic [Lanes-1:0][RootW-1:0]      root_q [RootW];
  logic [SideW-1:0]                 side_q [RootW];

  for (genvar g = 0; g < RootW; g++) begin : g_stage
    logic                         v_in;
    logic [Lanes-1:0][RadW-1:0]   rad_in;
    logic [Lanes-1:0][RemW-1:0]   rem_in;
    logic [Lanes-1:0][RootW-1:0]  root_in;
    logic [SideW-1:0]             side_in;
    logic [Lanes-1:0][RadW-1:0]   rad_d;
    logic [Lanes-1:0][RemW-1:0]   rem_d;
    logic [Lanes-1:0][RootW-1:0]  root_d;
    logic [Lanes-1:0][RemW-1:0]   tmp;
    logic [Lanes-1:0][RemW-1:0]   trial;
    logic [Lanes-1:0]             ge;

    if (g == 0) begin : g_first
      assign v_in    = vld_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_comb begin
      for (int l = 0; l < Lanes; l++) begin
        tmp[l]    = {rem_in[l][RemW-3:0], rad_in[l][RadW-1 -: 2]};
        trial[l]  = {root_in[l], 2'b01};
        ge[l]     = (tmp[l] >= trial[l]);
        rem_d[l]  = ge[l] ? (tmp[l] - trial[l]) : tmp[l];
        root_d[l] = {root_in[l][RootW-2:0], ge[l]};
        rad_d[l]  = {rad_in[l][RadW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[g]  <= rad_d;
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
        side_q[g] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[RootW-1];
  assign root_o = root_q[RootW-1];
  assign side_o = side_q[RootW-1];

endmodule

`default_nettype wire

[src/rmq_div.sv]
// ----------------------------------------------------------------------------
// rmq_div
// pipelined restoring divider, one quotient bit per stage, shared divisor
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div #(
  parameter int unsigned NumW  = 30,
  parameter int unsigned DenW  = 16,
  parameter int unsigned QW    = 15,
  parameter int unsigned Lanes = 4,
  parameter int unsigned SideW = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [Lanes-1:0][NumW-1:0]  num_i,
  input  logic [DenW-1:0]             den_i,
  input  logic [SideW-1:0]            side_i,
  output logic                        vld_o,
  output logic [Lanes-1:0][QW-1:0]    quo_o,
  output logic [SideW-1:0]            side_o
);

  localparam int unsigned RemW = DenW + 1;

  logic [QW-1:0]               vld_q;
  logic [Lanes-1:0][QW-1:0]    low_q  [QW];
  logic [Lanes-1:0][RemW-1:0]  rem_q  [QW];
  logic [Lanes-1:0][QW-1:0]    quo_q  [QW];
  logic [DenW-1:0]             den_q  [QW];
  logic [SideW-1:0]            side_q [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic                        v_in;
    logic [Lanes-1:0][QW-1:0]    low_in;
    logic [Lanes-1:0][RemW-1:0]  rem_in;
    logic [Lanes-1:0][QW-1:0]    quo_in;
    logic [DenW-1:0]             den_in;
    logic [SideW-1:0]            side_in;
    logic [Lanes-1:0][QW-1:0]    low_d;
    logic [Lanes-1:0][RemW-1:0]  rem_d;
    logic [Lanes-1:0][QW-1:0]    quo_d;
    logic [Lanes-1:0][RemW-1:0]  tmp;
    logic [Lanes-1:0]            ge;

    if (g == 0) begin : g_first
      assign v_in    = vld_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign quo_in  = '0;
      for (genvar l = 0; l < Lanes; l++) begin : g_lane
        assign low_in[l] = num_i[l][QW-1:0];
        assign rem_in[l] = RemW'(num_i[l][NumW-1:QW]);
      end
    end else begin : g_next
      assign v_in    = vld_q[g-1];
      assign low_in  = low_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign quo_in  = quo_q[g-1];
      assign den_in  = den_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_comb begin
      for (int l = 0; l < Lanes; l++) begin
        tmp[l]   = {rem_in[l][DenW-1:0], low_in[l][QW-1]};
        ge[l]    = (tmp[l] >= RemW'(den_in));
        rem_d[l] = ge[l] ? (tmp[l] - RemW'(den_in)) : tmp[l];
        quo_d[l] = {quo_in[l][QW-2:0], ge[l]};
        low_d[l] = {low_in[l][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        low_q[g]  <= low_d;
        rem_q[g]  <= rem_d;
        quo_q[g]  <= quo_d;
        den_q[g]  <= den_in;
        side_q[g] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign quo_o  = quo_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

`default_nettype wire

[src/rotation_matrix_to_quaternion.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// order: input register, component roots, squares, sum, norm root, dividends,
// divider, output register; the roots and divider resolve one bit per stage
// throughput: one item per cycle; the whole pipeline stalls while the output
// item waits
// reset clears all valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion #(
  parameter int unsigned IN_WIDTH  = 16,
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // row0_col0, row0_col1, row0_col2, row1_col0 .. row2_col2
  input  logic [((9*IN_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z
  output logic [4*rmq_pkg::OutW-1:0]             m_axis_tdata
);

  localparam int unsigned BigW  = (IN_WIDTH > FRAC_BITS + 1) ? IN_WIDTH : FRAC_BITS + 1;
  localparam int unsigned EW    = BigW + 3;
  localparam int unsigned UW    = EW - 1;
  localparam int unsigned R1    = UW + FRAC_BITS - 2;
  localparam int unsigned R1E   = R1 + (R1 % 2);
  localparam int unsigned MW    = R1E / 2;
  localparam int unsigned SqW   = 2 * MW;
  localparam int unsigned R2    = 2 * MW + 2;
  localparam int unsigned NW    = R2 / 2;
  localparam int unsigned QW    = FRAC_BITS + 1;
  localparam int unsigned NumW  = MW + FRAC_BITS + 1;
  localparam int unsigned NC    = rmq_pkg::NumComp;
  localparam longint unsigned OneV = 64'd1 << FRAC_BITS;
  localparam longint unsigned LimV = (OneV > rmq_pkg::OutMax) ? rmq_pkg::OutMax : OneV;
  localparam logic signed [EW-1:0] OneS = EW'(OneV);

  logic en;
  logic out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // front: candidate sums, clamp, pick, signs
  logic signed [IN_WIDTH-1:0] r [9];
  for (genvar k = 0; k < 9; k++) begin : g_unpack
    assign r[k] = s_axis_tdata[k*IN_WIDTH +: IN_WIDTH];
  end

  logic signed [EW-1:0]       s [NC];
  logic [NC-1:0][UW-1:0]      u;
  logic [NC-1:0][R1E-1:0]     rad1_d;
  logic [1:0]                 best;
  logic [UW-1:0]              best_v;
  logic signed [IN_WIDTH:0]   dx, dy, dz, pxy, pxz, pyz;
  rmq_pkg::negs_t             neg_d;

  always_comb begin
    s[0] = EW'(r[0]) + EW'(r[4]) + EW'(r[8]) + OneS;
    s[1] = EW'(r[0]) - EW'(r[4]) - EW'(r[8]) + OneS;
    s[2] = -EW'(r[0]) + EW'(r[4]) - EW'(r[8]) + OneS;
    s[3] = -EW'(r[0]) - EW'(r[4]) + EW'(r[8]) + OneS;
    for (int i = 0; i < NC; i++) begin
      u[i]      = s[i][EW-1] ? '0 : s[i][UW-1:0];
      rad1_d[i] = R1E'(u[i]) << (FRAC_BITS - 2);
    end
    best   = 2'd0;
    best_v = u[0];
    for (int i = 1; i < NC; i++) begin
      if (u[i] > best_v) begin
        best   = 2'(i);
        best_v = u[i];
      end
    end
    dx  = (IN_WIDTH+1)'(r[7]) - (IN_WIDTH+1)'(r[5]);
    dy  = (IN_WIDTH+1)'(r[2]) - (IN_WIDTH+1)'(r[6]);
    dz  = (IN_WIDTH+1)'(r[3]) - (IN_WIDTH+1)'(r[1]);
    pxy = (IN_WIDTH+1)'(r[3]) + (IN_WIDTH+1)'(r[1]);
    pxz = (IN_WIDTH+1)'(r[2]) + (IN_WIDTH+1)'(r[6]);
    pyz = (IN_WIDTH+1)'(r[7]) + (IN_WIDTH+1)'(r[5]);
    unique case (best)
      2'd0:    neg_d = {dz[IN_WIDTH], dy[IN_WIDTH], dx[IN_WIDTH], 1'b0};
      2'd1:    neg_d = {pxz[IN_WIDTH], pxy[IN_WIDTH], 1'b0, dx[IN_WIDTH]};
      2'd2:    neg_d = {pyz[IN_WIDTH], 1'b0, pxy[IN_WIDTH], dy[IN_WIDTH]};
      default: neg_d = {1'b0, pyz[IN_WIDTH], pxz[IN_WIDTH], dz[IN_WIDTH]};
    endcase
  end

  logic                    vld0_q;
  logic [NC-1:0][R1E-1:0]  rad1_q;
  rmq_pkg::negs_t          neg0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en) begin
      vld0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad1_q <= rad1_d;
      neg0_q <= neg_d;
    end
  end

  // component magnitudes
  logic                  vld1;
  logic [NC-1:0][MW-1:0] m1;
  rmq_pkg::negs_t        neg1;

  rmq_isqrt #(.RadW(R1E), .Lanes(NC), .SideW(NC)) u_root_comp (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .vld_i (vld0_q), .rad_i (rad1_q), .side_i (neg0_q),
    .vld_o (vld1), .root_o (m1), .side_o (neg1)
  );

  // squares, then their sum
  logic                   vld2_q, vld3_q;
  logic [NC-1:0][SqW-1:0] sq_q;
  logic [NC-1:0][MW-1:0]  m2_q, m3_q;
  rmq_pkg::negs_t         neg2_q, neg3_q;
  logic [0:0][R2-1:0]     sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en) begin
      vld2_q <= vld1;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        sq_q[i] <= SqW'(m1[i]) * SqW'(m1[i]);
      end
      m2_q     <= m1;
      neg2_q   <= neg1;
      sum_q[0] <= R2'(sq_q[0]) + R2'(sq_q[1]) + R2'(sq_q[2]) + R2'(sq_q[3]);
      m3_q     <= m2_q;
      neg3_q   <= neg2_q;
    end
  end

  // norm
  logic                  vld4;
  logic [0:0][NW-1:0]    nrm;
  logic [NC-1:0][MW-1:0] m4;
  rmq_pkg::negs_t        neg4;

  rmq_isqrt #(.RadW(R2), .Lanes(1), .SideW(NC*MW+NC)) u_root_norm (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .vld_i (vld3_q), .rad_i (sum_q), .side_i ({m3_q, neg3_q}),
    .vld_o (vld4), .root_o (nrm), .side_o ({m4, neg4})
  );

  // dividends with rounding offset
  logic                    vld5_q;
  logic [NC-1:0][NumW-1:0] num_q;
  logic [NW-1:0]           den_q;
  rmq_pkg::negs_t          neg5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld5_q <= 1'b0;
    end else if (en) begin
      vld5_q <= vld4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        num_q[i] <= (NumW'(m4[i]) << FRAC_BITS) + NumW'(nrm[0] >> 1);
      end
      den_q  <= nrm[0];
      neg5_q <= neg4;
    end
  end

  logic                  vld6;
  logic [NC-1:0][QW-1:0] quo;
  rmq_pkg::negs_t        neg6;

  rmq_div #(.NumW(NumW), .DenW(NW), .QW(QW), .Lanes(NC), .SideW(NC)) u_div (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .vld_i (vld5_q), .num_i (num_q), .den_i (den_q), .side_i (neg5_q),
    .vld_o (vld6), .quo_o (quo), .side_o (neg6)
  );

  // saturate, sign, output register
  logic [NC-1:0][rmq_pkg::OutW-1:0] out_d;
  logic [NC-1:0][rmq_pkg::OutW-1:0] out_q;
  logic [31:0]                      qx;
  logic [rmq_pkg::OutW-1:0]         mag;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      qx       = 32'(quo[i]);
      mag      = (64'(qx) > LimV) ? rmq_pkg::OutW'(LimV) : {1'b0, qx[rmq_pkg::OutW-2:0]};
      out_d[i] = neg6[i] ? (~mag + 1'b1) : mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld6;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  localparam logic signed [rmq_pkg::OutW-1:0] LimS = rmq_pkg::OutW'(LimV);

  a_range_w : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(out_q[0]) <= LimS) && ($signed(out_q[0]) >= -LimS))
    else $error("quat_w out of range");

  a_range_x : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(out_q[1]) <= LimS) && ($signed(out_q[1]) >= -LimS))
    else $error("quat_x out of range");

  a_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q != '0))
    else $error("all quaternion components zero");

  a_stall_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(vld0_q) && $stable(vld5_q))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

[test/rmq_checker.sv]
// ----------------------------------------------------------------------------
// rmq_checker
// watches both stream ports, predicts each quaternion and compares it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmq_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o
);

  logic [63:0] quat_q[$];

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] to_quaternion(input logic [143:0] d);
    longint r[9];
    longint s[4];
    logic [63:0] m[4];
    logic neg[4];
    logic dx, dy, dz, pxy, pxz, pyz;
    logic [63:0] sum, n, q;
    longint v;
    logic [63:0] res;
    int best;
    best = 0;
    for (int i = 0; i < 9; i++) r[i] = longint'($signed(d[16*i +: 16]));
    s[0] = r[0] + r[4] + r[8] + 16384;
    s[1] = r[0] - r[4] - r[8] + 16384;
    s[2] = -r[0] + r[4] - r[8] + 16384;
    s[3] = -r[0] - r[4] + r[8] + 16384;
    for (int i = 0; i < 4; i++) begin
      if (s[i] < 0) s[i] = 0;
      m[i] = isqrt(64'(s[i]) << 12);
    end
    for (int i = 1; i < 4; i++) if (s[i] > s[best]) best = i;
    dx = (r[7] - r[5]) < 0;
    dy = (r[2] - r[6]) < 0;
    dz = (r[3] - r[1]) < 0;
    pxy = (r[3] + r[1]) < 0;
    pxz = (r[2] + r[6]) < 0;
    pyz = (r[7] + r[5]) < 0;
    case (best)
      0: begin neg[0] = 0; neg[1] = dx; neg[2] = dy; neg[3] = dz; end
      1: begin neg[0] = dx; neg[1] = 0; neg[2] = pxy; neg[3] = pxz; end
      2: begin neg[0] = dy; neg[1] = pxy; neg[2] = 0; neg[3] = pyz; end
      default: begin neg[0] = dz; neg[1] = pxz; neg[2] = pyz; neg[3] = 0; end
    endcase
    sum = m[0]*m[0] + m[1]*m[1] + m[2]*m[2] + m[3]*m[3];
    n = isqrt(sum);
    for (int i = 0; i < 4; i++) begin
      q = 0;
      if (n != 0) q = ((m[i] << 14) + (n >> 1)) / n;
      if (q > 16384) q = 16384;
      v = neg[i] ? -longint'(q) : longint'(q);
      res[16*i +: 16] = v[15:0];
    end
    return res;
  endfunction

  initial fail_count_o = 0;
  assign pending_o = quat_q.size();

  always @(posedge clk_i) begin
    logic [63:0] exp_q;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) quat_q.push_back(to_quaternion(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (quat_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected item %h", m_axis_tdata);
        end else begin
          exp_q = quat_q.pop_front();
          if (exp_q !== m_axis_tdata) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch w x y z: expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                $signed(exp_q[15:0]), $signed(exp_q[31:16]), $signed(exp_q[47:32]),
                $signed(exp_q[63:48]), $signed(m_axis_tdata[15:0]),
                $signed(m_axis_tdata[31:16]), $signed(m_axis_tdata[47:32]),
                $signed(m_axis_tdata[63:48]));
          end
        end
      end
    end
  end

endmodule

[test/tb_rotation_matrix_to_quaternion.sv]
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// drives directed and random matrices with random idling on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;

  localparam int NumRandom = 1350;
  localparam int CycleLimit = 400000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [63:0]  m_axis_tdata;
  int           fail_count;
  int           pending;
  int           cycles = 0;
  bit           calm = 0;

  always #4 clk_i = ~clk_i;

  rotation_matrix_to_quaternion DUT (.*);

  rmq_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // sink stalls in bursts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 0;
        n = $urandom_range(1, 19);
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      n = $urandom_range(1, 30);
      repeat (n) @(posedge clk_i);
    end
  end

  task automatic send_matrix(input logic [143:0] d);
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic gap();
    int n;
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 0;
      n = $urandom_range(1, 19);
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [143:0] diag(input logic [15:0] a, b, c);
    logic [143:0] d;
    d = '0;
    d[15:0] = a;
    d[79:64] = b;
    d[143:128] = c;
    return d;
  endfunction

  function automatic logic [143:0] rand_matrix();
    logic [143:0] d;
    for (int i = 0; i < 9; i++) begin
      case ($urandom_range(0, 4))
        0: d[16*i +: 16] = 16'($urandom);
        1: d[16*i +: 16] = 16'(int'($urandom_range(0, 32768)) - 16384);
        2: d[16*i +: 16] = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        3: d[16*i +: 16] = 16'(int'($urandom_range(0, 64)) - 32);
        default: d[16*i +: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hc000;
      endcase
    end
    return d;
  endfunction

  initial begin
    logic [143:0] d;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // identity and the half-turn rotations, each component as the largest
    send_matrix(diag(16'h4000, 16'h4000, 16'h4000));
    send_matrix(diag(16'h4000, 16'hc000, 16'hc000));
    send_matrix(diag(16'hc000, 16'h4000, 16'hc000));
    send_matrix(diag(16'hc000, 16'hc000, 16'h4000));
    // ties between candidates and all-zero matrix
    send_matrix('0);
    send_matrix(diag(16'h0000, 16'h0000, 16'hc000));
    // extremes of every element
    send_matrix({9{16'h7fff}});
    send_matrix({9{16'h8000}});
    send_matrix({9{16'hffff}});
    send_matrix({9{16'h0001}});
    d = diag(16'h8000, 16'h8000, 16'h8000);
    send_matrix(d);
    d = diag(16'h7fff, 16'h8000, 16'h8000);
    send_matrix(d);
    // signs from off-diagonal terms, zero differences counting positive
    for (int k = 0; k < 6; k++) begin
      d = diag(16'h4000, 16'h4000, 16'h4000);
      d[16*(k % 3 + 1) +: 16] = 16'h2000;
      d[16*(8 - k % 3 - 1) +: 16] = k < 3 ? 16'he000 : 16'h2000;
      send_matrix(d);
    end
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 2) begin
        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge clk_i);
      end
      if (i == NumRandom - 150) calm = 1;
      send_matrix(rand_matrix());
      gap();
    end
    s_axis_tvalid <= 0;
    calm = 1;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
